[sv/keyboard_scancode_translator_defines.svh]
// Assertion macros shared by the keyboard scancode translator RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH
`define KEYBOARD_SCANCODE_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KST_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define KST_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/kst_pkg.sv]
// Shared types, key codes and result codes for the keyboard scancode translator.
// Depends on nothing; imported by every module of the block.
package kst_pkg;

    localparam int KEY_COUNT = 128;
    localparam int MAP_DEPTH = 4 * KEY_COUNT;
    localparam int MAP_AW    = $clog2(MAP_DEPTH);

    // Commands
    localparam logic [1:0] CMD_KEY  = 2'd0;
    localparam logic [1:0] CMD_TICK = 2'd1;
    localparam logic [1:0] CMD_MAP  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_INITIAL_DELAY = 2'd0;
    localparam logic [1:0] REG_REPEAT_PERIOD = 2'd1;
    localparam logic [1:0] REG_COOKED_MODE   = 2'd2;
    localparam logic [1:0] REG_XOFF_CHAR     = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_CHAR = 2'd0;
    localparam logic [1:0] KIND_FUNC = 2'd1;
    localparam logic [1:0] KIND_STOP = 2'd2;

    // Key codes
    localparam logic [6:0] KEY_SHIFT_L = 7'h60;
    localparam logic [6:0] KEY_SHIFT_R = 7'h61;
    localparam logic [6:0] KEY_CAPS    = 7'h62;
    localparam logic [6:0] KEY_CTRL    = 7'h63;
    localparam logic [6:0] KEY_ALT_L   = 7'h64;
    localparam logic [6:0] KEY_ALT_R   = 7'h65;
    localparam logic [6:0] KEY_F_FIRST = 7'h50;
    localparam logic [6:0] KEY_F_LAST  = 7'h59;
    localparam logic [6:0] KEY_F_BASE1 = 7'h4F;
    localparam logic [6:0] KEY_HELP    = 7'h5F;
    localparam logic [6:0] KEY_UP      = 7'h4C;
    localparam logic [6:0] KEY_DOWN    = 7'h4D;
    localparam logic [6:0] KEY_RIGHT   = 7'h4E;
    localparam logic [6:0] KEY_LEFT    = 7'h4F;

    // Characters and masks
    localparam logic [7:0] CHAR_ESC    = 8'h1B;
    localparam logic [7:0] CHAR_LBRKT  = 8'h5B;
    localparam logic [7:0] CHAR_A      = 8'h41;
    localparam logic [7:0] CHAR_B      = 8'h42;
    localparam logic [7:0] CHAR_C      = 8'h43;
    localparam logic [7:0] CHAR_D      = 8'h44;
    localparam logic [7:0] CHAR_H      = 8'h48;
    localparam logic [7:0] CHAR_J      = 8'h4A;
    localparam logic [7:0] CTRL_MASK   = 8'h1F;
    localparam logic [4:0] FUNC_SHIFT  = 5'd10;

    // Context captured with a keymap lookup
    typedef struct packed {
        logic [6:0] code;
        logic       shifted;
        logic       alted;
        logic       ctrl;
    } t_ctx;

    typedef enum logic [1:0] {
        SEQ_NONE,
        SEQ_ONE,
        SEQ_ANSI
    } t_seq_mode;

    // Result sequence of one translated key
    typedef struct packed {
        t_seq_mode  mode;
        logic [1:0] kind;
        logic [7:0] chr;
        logic       oper;
        logic [4:0] fidx;
        logic       second;
    } t_desc;

    // Letter keys follow caps lock
    function automatic logic is_letter(input logic [6:0] code);
        return (code >= 7'h10 && code <= 7'h19) || (code >= 7'h20 && code <= 7'h28) ||
               (code >= 7'h31 && code <= 7'h37);
    endfunction

endpackage

[sv/kst_keymap.sv]
// Keymap storage: four banks of KEY_COUNT 8-bit entries, one write, one read port.
// Depends on kst_pkg for the depth and address width.
module kst_keymap
    import kst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [MAP_AW-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [MAP_AW-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [MAP_DEPTH];
    logic [7:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read, held between lookups
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[sv/kst_front.sv]
// Input stage: modifier tracking, typematic counter, keymap access and lookup register.
// Depends on kst_pkg for commands, key codes and the lookup context type.
module kst_front
    import kst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_key_byte,
    input  logic [MAP_AW-1:0] i_map_addr,
    input  logic [7:0]        i_map_data,
    input  logic [7:0]        i_initial_delay,
    input  logic [7:0]        i_repeat_period,
    input  logic              i_a_take,
    output logic              o_in_ready,
    output logic              o_wr_en,
    output logic [MAP_AW-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output logic              o_rd_en,
    output logic [MAP_AW-1:0] o_rd_addr,
    output logic              o_a_valid,
    output t_ctx              o_a_ctx
);

    logic       r_shift_l, r_shift_r, r_alt_l, r_alt_r, r_ctrl, r_caps;
    logic [6:0] r_rep_code;
    logic [7:0] r_rep_count;
    logic       r_a_valid;
    t_ctx       r_a_ctx;

    logic       make;
    logic [6:0] code;
    logic       is_mod;
    logic       shifted, alted;
    logic       key_cmd, tick_cmd;
    logic       key_xlate, tick_fire, xlate;
    logic [6:0] xcode;

    // Decode the raw byte
    always_comb begin
        make      = i_key_byte[0];
        code      = ~i_key_byte[7:1];
        is_mod    = code inside {[KEY_SHIFT_L:KEY_ALT_R]};
        shifted   = r_shift_l | r_shift_r;
        alted     = r_alt_l | r_alt_r;
        key_cmd   = i_accept && (i_cmd == CMD_KEY);
        tick_cmd  = i_accept && (i_cmd == CMD_TICK);
        key_xlate = key_cmd && !is_mod && make;
        tick_fire = tick_cmd && (r_rep_count == 8'd1);
        xlate     = key_xlate || tick_fire;
        xcode     = key_xlate ? code : r_rep_code;
    end

    // Keymap ports; bank bits come from the modifiers held now
    assign o_wr_en   = i_accept && (i_cmd == CMD_MAP);
    assign o_wr_addr = i_map_addr;
    assign o_wr_data = i_map_data;
    assign o_rd_en   = xlate;
    assign o_rd_addr = {alted, shifted | (r_caps & is_letter(xcode)), xcode};

    // Modifier bits and typematic state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_l   <= 1'b0;
            r_shift_r   <= 1'b0;
            r_alt_l     <= 1'b0;
            r_alt_r     <= 1'b0;
            r_ctrl      <= 1'b0;
            r_caps      <= 1'b0;
            r_rep_code  <= '0;
            r_rep_count <= '0;
        end else if (key_cmd) begin
            case (code)
                KEY_SHIFT_L: r_shift_l <= make;
                KEY_SHIFT_R: r_shift_r <= make;
                KEY_CAPS:    r_caps    <= make;
                KEY_CTRL:    r_ctrl    <= make;
                KEY_ALT_L:   r_alt_l   <= make;
                KEY_ALT_R:   r_alt_r   <= make;
                default: begin
                    if (!make) begin
                        r_rep_count <= '0;
                    end else begin
                        r_rep_code  <= code;
                        r_rep_count <= i_initial_delay;
                    end
                end
            endcase
        end else if (tick_cmd && (r_rep_count != 8'd0)) begin
            r_rep_count <= tick_fire ? i_repeat_period : r_rep_count - 8'd1;
        end
    end

    // Lookup register, paired with the keymap read data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (xlate) begin
            r_a_valid <= 1'b1;
        end else if (i_a_take) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (xlate) begin
            r_a_ctx.code    <= xcode;
            r_a_ctx.shifted <= shifted;
            r_a_ctx.alted   <= alted;
            r_a_ctx.ctrl    <= r_ctrl;
        end
    end

    assign o_in_ready = !r_a_valid || i_a_take;
    assign o_a_valid  = r_a_valid;
    assign o_a_ctx    = r_a_ctx;

endmodule

[sv/kst_serializer.sv]
// Result builder and serializer: turns a keymap lookup into up to six output words.
// Depends on kst_pkg and the assertion macros in keyboard_scancode_translator_defines.svh.
`include "keyboard_scancode_translator_defines.svh"

module kst_serializer
    import kst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_a_valid,
    input  t_ctx       i_a_ctx,
    input  logic [7:0] i_map_q,
    input  logic       i_cooked_mode,
    input  logic [7:0] i_xoff_char,
    input  logic       i_ready,
    output logic       o_a_take,
    output logic       o_valid,
    output logic [1:0] o_kind,
    output logic [7:0] o_char_code,
    output logic       o_to_operator,
    output logic [4:0] o_func_index,
    output logic       o_last
);

    logic       r_busy;
    t_desc      r_desc;
    logic [1:0] r_pos;
    logic       r_half;
    logic       r_o_valid;
    logic [1:0] r_o_kind;
    logic [7:0] r_o_char;
    logic       r_o_oper;
    logic [4:0] r_o_fidx;
    logic       r_o_last;

    t_desc      desc;
    logic [7:0] masked;
    logic [1:0] e_kind;
    logic [7:0] e_char;
    logic       e_oper;
    logic [4:0] e_fidx;
    logic       e_final;
    logic       out_free, emit, ser_free;

    // Build the result sequence from the lookup
    always_comb begin
        desc   = '{mode: SEQ_NONE, kind: KIND_CHAR, chr: 8'd0, oper: 1'b0,
                   fidx: 5'd0, second: 1'b0};
        masked = i_a_ctx.ctrl ? (i_map_q & CTRL_MASK) : i_map_q;
        if (i_map_q != 8'd0) begin
            desc.mode = SEQ_ONE;
            if (i_cooked_mode && (masked == i_xoff_char)) begin
                desc.kind = KIND_STOP;
            end else begin
                desc.chr = masked;
            end
        end else if (i_a_ctx.code inside {[KEY_F_FIRST:KEY_F_LAST]}) begin
            desc.mode = SEQ_ONE;
            if (i_a_ctx.ctrl && i_a_ctx.alted) begin
                desc.chr  = {1'b0, i_a_ctx.code - KEY_F_BASE1};
                desc.oper = 1'b1;
            end else begin
                desc.kind = KIND_FUNC;
                desc.fidx = 5'(i_a_ctx.code - KEY_F_FIRST)
                          + (i_a_ctx.shifted ? FUNC_SHIFT : 5'd0);
            end
        end else begin
            case (i_a_ctx.code)
                KEY_HELP: begin
                    desc.mode   = SEQ_ANSI;
                    desc.chr    = CHAR_H;
                    desc.second = i_a_ctx.shifted;
                end
                KEY_UP: begin
                    desc.mode = SEQ_ANSI;
                    desc.chr  = CHAR_A;
                end
                KEY_LEFT: begin
                    desc.mode = SEQ_ANSI;
                    desc.chr  = CHAR_D;
                end
                KEY_RIGHT: begin
                    desc.mode = SEQ_ANSI;
                    desc.chr  = CHAR_C;
                end
                KEY_DOWN: begin
                    desc.mode = SEQ_ANSI;
                    desc.chr  = CHAR_B;
                end
                default: desc.mode = SEQ_NONE;
            endcase
        end
    end

    // Current word of the held sequence
    always_comb begin
        e_kind  = KIND_CHAR;
        e_char  = 8'd0;
        e_oper  = 1'b0;
        e_fidx  = 5'd0;
        e_final = 1'b1;
        case (r_desc.mode)
            SEQ_ONE: begin
                e_kind = r_desc.kind;
                e_char = r_desc.chr;
                e_oper = r_desc.oper;
                e_fidx = r_desc.fidx;
            end
            SEQ_ANSI: begin
                case (r_pos)
                    2'd0:    e_char = CHAR_ESC;
                    2'd1:    e_char = CHAR_LBRKT;
                    default: e_char = r_half ? CHAR_J : r_desc.chr;
                endcase
                e_final = (r_pos == 2'd2) && (!r_desc.second || r_half);
            end
            default: e_final = 1'b1;
        endcase
    end

    // Handshake between the stages
    assign out_free = !r_o_valid || i_ready;
    assign emit     = r_busy && out_free;
    assign ser_free = !r_busy || (emit && e_final);
    assign o_a_take = i_a_valid && ((desc.mode == SEQ_NONE) || ser_free);

    // Sequence holder
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= 2'd0;
            r_half <= 1'b0;
        end else if (o_a_take && (desc.mode != SEQ_NONE)) begin
            r_busy <= 1'b1;
            r_pos  <= 2'd0;
            r_half <= 1'b0;
        end else if (emit) begin
            if (e_final) begin
                r_busy <= 1'b0;
                r_pos  <= 2'd0;
                r_half <= 1'b0;
            end else if (r_pos == 2'd2) begin
                r_pos  <= 2'd0;
                r_half <= 1'b1;
            end else begin
                r_pos  <= r_pos + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_a_take && (desc.mode != SEQ_NONE)) begin
            r_desc <= desc;
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (emit) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_o_kind <= e_kind;
            r_o_char <= e_char;
            r_o_oper <= e_oper;
            r_o_fidx <= e_fidx;
            r_o_last <= e_final;
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_o_kind;
    assign o_char_code   = r_o_char;
    assign o_to_operator = r_o_oper;
    assign o_func_index  = r_o_fidx;
    assign o_last        = r_o_last;

    // A held sequence always has words to give
    `KST_ASSERT_NOW(a_busy_mode, i_clk, i_rst_n, r_busy, r_desc.mode != SEQ_NONE,
        "serializer busy with an empty sequence")
    // Position advances only inside an escape sequence
    `KST_ASSERT_NOW(a_pos_ansi, i_clk, i_rst_n, r_pos != 2'd0,
        r_busy && (r_desc.mode == SEQ_ANSI) && (r_pos != 2'd3),
        "sequence position outside an escape sequence")
    // Second escape triple only when one was requested
    `KST_ASSERT_NOW(a_half_second, i_clk, i_rst_n, r_half, r_busy && r_desc.second,
        "second escape triple without a request")
    // A final word frees the serializer unless a new lookup is loaded
    `KST_ASSERT_NEXT(a_final_frees, i_clk, i_rst_n,
        emit && e_final && !o_a_take, !r_busy,
        "serializer still busy after its final word")

endmodule

[sv/keyboard_scancode_translator.sv]
// Keyboard scancode translator: configuration registers and block top level.
// Depends on kst_pkg, kst_keymap, kst_front and kst_serializer.
//
// Usage: one input channel (i_valid/o_ready) takes commands: a raw keyboard
// byte, a typematic tick, or a keymap entry write. One output channel
// (o_valid/i_ready) gives result words: character, function key request or
// output stop, with o_last on the final word caused by an input word. A key
// press gives up to six words (help with shift: two ESC [ x triples).
// A translated key passes the keymap read and lookup registers, loaded at the
// accepting edge, then the sequence register, then the output register.
// Throughput: one input word per cycle while each gives at most one word and
// the receiver is ready; a multi-word result holds the input until its last
// word goes to the single output register that the serializer feeds.
// Keymap writes and words that give no result go through at one per cycle
// while no held lookup stalls the input. Configuration: i_cfg_valid and
// o_cfg_ready, always ready; the user must write it only while idle, which
// the block itself does not enforce. Reset (i_rst_n low, synchronous) clears
// modifiers, typematic state and all handshake state and loads register
// defaults; the keymap is not cleared. When the receiver stalls, the output
// word holds and the input stalls once the lookup and serializer stages are full.
module keyboard_scancode_translator
    import kst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    // Input words
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_key_byte,
    input  logic [MAP_AW-1:0] i_map_addr,
    input  logic [7:0]        i_map_data,
    // Result words
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_kind,
    output logic [7:0]        o_char_code,
    output logic              o_to_operator,
    output logic [4:0]        o_func_index,
    output logic              o_last
);

    logic [7:0]        r_initial_delay;
    logic [7:0]        r_repeat_period;
    logic              r_cooked_mode;
    logic [7:0]        r_xoff_char;

    logic              accept;
    logic              a_take;
    logic              wr_en, rd_en;
    logic [MAP_AW-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, map_q;
    logic              a_valid;
    t_ctx              a_ctx;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_initial_delay <= 8'd18;
            r_repeat_period <= 8'd6;
            r_cooked_mode   <= 1'b1;
            r_xoff_char     <= 8'd19;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INITIAL_DELAY: r_initial_delay <= i_cfg_data;
                REG_REPEAT_PERIOD: r_repeat_period <= i_cfg_data;
                REG_COOKED_MODE:   r_cooked_mode   <= i_cfg_data[0];
                REG_XOFF_CHAR:     r_xoff_char     <= i_cfg_data;
                default:           r_xoff_char     <= r_xoff_char;
            endcase
        end
    end

    assign accept = i_valid && o_ready;

    kst_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_cmd           (i_cmd),
        .i_key_byte      (i_key_byte),
        .i_map_addr      (i_map_addr),
        .i_map_data      (i_map_data),
        .i_initial_delay (r_initial_delay),
        .i_repeat_period (r_repeat_period),
        .i_a_take        (a_take),
        .o_in_ready      (o_ready),
        .o_wr_en         (wr_en),
        .o_wr_addr       (wr_addr),
        .o_wr_data       (wr_data),
        .o_rd_en         (rd_en),
        .o_rd_addr       (rd_addr),
        .o_a_valid       (a_valid),
        .o_a_ctx         (a_ctx)
    );

    kst_keymap u_keymap (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (map_q)
    );

    kst_serializer u_serializer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_a_valid     (a_valid),
        .i_a_ctx       (a_ctx),
        .i_map_q       (map_q),
        .i_cooked_mode (r_cooked_mode),
        .i_xoff_char   (r_xoff_char),
        .i_ready       (i_ready),
        .o_a_take      (a_take),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_char_code   (o_char_code),
        .o_to_operator (o_to_operator),
        .o_func_index  (o_func_index),
        .o_last        (o_last)
    );

endmodule

[verif/kst_translation_checker.sv]
// Checker for the keyboard scancode translator: watches the config, command and
// result channels, predicts the result words and compares them in order.
// Depends on kst_pkg for port widths, commands, key codes and result kinds.
module kst_translation_checker
    import kst_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    input  logic              o_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_key_byte,
    input  logic [MAP_AW-1:0] i_map_addr,
    input  logic [7:0]        i_map_data,
    input  logic              o_valid,
    input  logic              i_ready,
    input  logic [1:0]        o_kind,
    input  logic [7:0]        o_char_code,
    input  logic              o_to_operator,
    input  logic [4:0]        o_func_index,
    input  logic              o_last,
    output int                o_errors,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] chr;
        logic       oper;
        logic [4:0] fidx;
        logic       last;
    } t_result_word;

    // Register copies
    logic [7:0] cfg_delay;
    logic [7:0] cfg_period;
    logic       cfg_cooked;
    logic [7:0] cfg_xoff;

    // Translator state
    logic [7:0] keymap_copy [MAP_DEPTH];
    logic       shift_l, shift_r, alt_l, alt_r, ctrl_down, caps_down;
    logic [6:0] repeat_key;
    logic [7:0] repeat_left;

    t_result_word key_words[$];
    t_result_word expected_words[$];
    int           mismatches = 0;

    task automatic push_word(input logic [1:0] kind, input logic [7:0] chr,
                             input logic oper, input logic [4:0] fidx);
        t_result_word w;
        w.kind = kind;
        w.chr  = chr;
        w.oper = oper;
        w.fidx = fidx;
        w.last = 1'b0;
        key_words.push_back(w);
    endtask

    task automatic push_escape(input logic [7:0] letter);
        push_word(KIND_CHAR, CHAR_ESC, 1'b0, 5'd0);
        push_word(KIND_CHAR, CHAR_LBRKT, 1'b0, 5'd0);
        push_word(KIND_CHAR, letter, 1'b0, 5'd0);
    endtask

    // Keymap lookup with modifiers, then the fallbacks for empty entries
    task automatic translate_key(input logic [6:0] code);
        logic                shifted, alted, letter;
        logic [MAP_AW-1:0]   idx;
        logic [7:0]          c;
        shifted = shift_l | shift_r;
        alted   = alt_l | alt_r;
        letter  = (code >= 7'h10 && code <= 7'h19) || (code >= 7'h20 && code <= 7'h28) ||
                  (code >= 7'h31 && code <= 7'h37);
        idx = {2'b00, code};
        if (shifted || (caps_down && letter)) idx[7] = 1'b1;
        if (alted) idx[8] = 1'b1;
        c = keymap_copy[idx];
        if (c != 8'h00) begin
            if (ctrl_down) c = c & CTRL_MASK;
            if (cfg_cooked && c == cfg_xoff) push_word(KIND_STOP, 8'h00, 1'b0, 5'd0);
            else push_word(KIND_CHAR, c, 1'b0, 5'd0);
        end else if (code >= KEY_F_FIRST && code <= KEY_F_LAST) begin
            if (ctrl_down && alted) begin
                push_word(KIND_CHAR, {1'b0, code - KEY_F_BASE1}, 1'b1, 5'd0);
            end else begin
                push_word(KIND_FUNC, 8'h00, 1'b0,
                          5'(code - KEY_F_FIRST) + (shifted ? FUNC_SHIFT : 5'd0));
            end
        end else begin
            case (code)
                KEY_HELP: begin
                    push_escape(CHAR_H);
                    if (shifted) push_escape(CHAR_J);
                end
                KEY_UP:    push_escape(CHAR_A);
                KEY_LEFT:  push_escape(CHAR_D);
                KEY_RIGHT: push_escape(CHAR_C);
                KEY_DOWN:  push_escape(CHAR_B);
                default: ;
            endcase
        end
    endtask

    // Expected result words of one accepted command word
    task automatic predict_command(input logic [1:0] cmd, input logic [7:0] raw,
                                   input logic [MAP_AW-1:0] addr, input logic [7:0] data);
        logic [6:0]   code;
        logic         make;
        t_result_word w;
        key_words.delete();
        make = raw[0];
        code = ~raw[7:1];
        case (cmd)
            CMD_KEY: begin
                case (code)
                    KEY_SHIFT_L: shift_l   = make;
                    KEY_SHIFT_R: shift_r   = make;
                    KEY_CAPS:    caps_down = make;
                    KEY_CTRL:    ctrl_down = make;
                    KEY_ALT_L:   alt_l     = make;
                    KEY_ALT_R:   alt_r     = make;
                    default: begin
                        if (!make) begin
                            repeat_left = 8'd0;
                        end else begin
                            repeat_key  = code;
                            repeat_left = cfg_delay;
                            translate_key(code);
                        end
                    end
                endcase
            end
            CMD_TICK: begin
                if (repeat_left != 8'd0) begin
                    repeat_left = repeat_left - 8'd1;
                    if (repeat_left == 8'd0) begin
                        translate_key(repeat_key);
                        repeat_left = cfg_period;
                    end
                end
            end
            CMD_MAP: keymap_copy[addr] = data;
            default: ;
        endcase
        if (key_words.size() > 0) begin
            w = key_words.pop_back();
            w.last = 1'b1;
            key_words.push_back(w);
        end
        foreach (key_words[k]) expected_words.push_back(key_words[k]);
    endtask

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            mismatches++;
        end
    endfunction

    // Sample all channels on the clock edge
    always @(posedge i_clk) begin : monitor
        t_result_word w;
        if (!i_rst_n) begin
            cfg_delay   = 8'd18;
            cfg_period  = 8'd6;
            cfg_cooked  = 1'b1;
            cfg_xoff    = 8'd19;
            shift_l     = 1'b0;
            shift_r     = 1'b0;
            alt_l       = 1'b0;
            alt_r       = 1'b0;
            ctrl_down   = 1'b0;
            caps_down   = 1'b0;
            repeat_key  = 7'd0;
            repeat_left = 8'd0;
            expected_words.delete();
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_INITIAL_DELAY: cfg_delay  = i_cfg_data;
                    REG_REPEAT_PERIOD: cfg_period = i_cfg_data;
                    REG_COOKED_MODE:   cfg_cooked = i_cfg_data[0];
                    REG_XOFF_CHAR:     cfg_xoff   = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && o_ready) begin
                predict_command(i_cmd, i_key_byte, i_map_addr, i_map_data);
            end
            if (o_valid && i_ready) begin
                if (expected_words.size() == 0) begin
                    $display("%0t: result word with none expected, kind %0h char %0h",
                             $time, o_kind, o_char_code);
                    mismatches++;
                end else begin
                    w = expected_words.pop_front();
                    check_field("kind", w.kind, o_kind);
                    check_field("char_code", w.chr, o_char_code);
                    check_field("to_operator", w.oper, o_to_operator);
                    check_field("func_index", w.fidx, o_func_index);
                    check_field("last", w.last, o_last);
                end
            end
        end
        o_errors  <= mismatches;
        o_pending <= expected_words.size();
    end

endmodule

[verif/keyboard_scancode_translator_tb.sv]
// Testbench top for the keyboard scancode translator: clock, reset, config
// writes, command words and result back-pressure; verdict from the checker.
// Depends on kst_pkg, keyboard_scancode_translator and kst_translation_checker.
module keyboard_scancode_translator_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kst_pkg::*;

    localparam int         HALF_PERIOD   = 5;
    localparam int         RESET_CYCLES  = 8;
    localparam int         SETTLE_CYCLES = 16;
    localparam int         HOLD_CYCLES   = 300;
    localparam int         PHASE_WORDS   = 25;
    localparam int         TIMEOUT_NS    = 5_000_000;
    localparam logic [1:0] CMD_UNUSED    = 2'd3;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              i_valid;
    logic              o_ready;
    logic [1:0]        i_cmd;
    logic [7:0]        i_key_byte;
    logic [MAP_AW-1:0] i_map_addr;
    logic [7:0]        i_map_data;
    logic              o_valid;
    logic              i_ready;
    logic [1:0]        o_kind;
    logic [7:0]        o_char_code;
    logic              o_to_operator;
    logic [4:0]        o_func_index;
    logic              o_last;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_requests  = 0;
    int holds_done     = 0;
    int items_sent     = 0;
    int fail_count;
    int words_pending;

    keyboard_scancode_translator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_cmd         (i_cmd),
        .i_key_byte    (i_key_byte),
        .i_map_addr    (i_map_addr),
        .i_map_data    (i_map_data),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_char_code   (o_char_code),
        .o_to_operator (o_to_operator),
        .o_func_index  (o_func_index),
        .o_last        (o_last)
    );

    kst_translation_checker u_checker (
        .*,
        .o_errors  (fail_count),
        .o_pending (words_pending)
    );

    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Result back-pressure, with an occasional long hold-off
    initial begin : ready_gen
        int n;
        i_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_requests) begin
                holds_done++;
                i_ready <= 1'b0;
                for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end else begin
                i_ready <= i_rst_n && ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One command word; valid stays up if the next word follows at once
    task automatic send_word(input logic [1:0] cmd, input logic [7:0] raw,
                             input logic [MAP_AW-1:0] addr, input logic [7:0] data);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_valid    <= 1'b1;
        i_cmd      <= cmd;
        i_key_byte <= raw;
        i_map_addr <= addr;
        i_map_data <= data;
        do @(posedge i_clk); while (!o_ready);
        items_sent++;
    endtask

    task automatic key_down(input logic [6:0] code);
        send_word(CMD_KEY, {~code, 1'b1}, MAP_AW'($urandom), 8'($urandom));
    endtask

    task automatic key_up(input logic [6:0] code);
        send_word(CMD_KEY, {~code, 1'b0}, MAP_AW'($urandom), 8'($urandom));
    endtask

    task automatic tick();
        send_word(CMD_TICK, 8'($urandom), MAP_AW'($urandom), 8'($urandom));
    endtask

    task automatic map_write(input logic [MAP_AW-1:0] addr, input logic [7:0] data);
        send_word(CMD_MAP, 8'($urandom), addr, data);
    endtask

    // Drop valid, wait out every expected word, then let no-result words clear
    task automatic wait_drain();
        int n;
        i_valid <= 1'b0;
        do @(posedge i_clk); while (words_pending != 0);
        for (n = 0; n < SETTLE_CYCLES; n++) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [7:0] delay, input logic [7:0] period,
                              input logic cooked, input logic [7:0] xoff);
        logic [1:0] regs [4];
        logic [7:0] vals [4];
        int         r;
        regs = '{REG_INITIAL_DELAY, REG_REPEAT_PERIOD, REG_COOKED_MODE, REG_XOFF_CHAR};
        vals = '{delay, period, {7'($urandom), cooked}, xoff};
        for (r = 0; r < 4; r++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[r];
            i_cfg_data  <= vals[r];
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // Typed key: cursor/function/help area, letter row, or the block around it
    function automatic logic [6:0] pick_key();
        logic [6:0] code;
        case ($urandom_range(3))
            0:       code = KEY_UP + 7'($urandom_range(0, 19));
            1:       code = 7'h10 + 7'($urandom_range(0, 15));
            default: code = 7'h40 + 7'($urandom_range(0, 31));
        endcase
        return code;
    endfunction

    // Keymap entry value; special keys are often left empty
    function automatic logic [7:0] pick_map_value(input logic [6:0] code,
                                                  input int special_zero_pct);
        int zero_pct;
        zero_pct = (code >= KEY_UP && code <= KEY_HELP) ? special_zero_pct : 20;
        if ($urandom_range(99) < zero_pct) return 8'h00;
        if ($urandom_range(1) == 0) return 8'($urandom_range(1, 31));
        return 8'($urandom_range(1, 255));
    endfunction

    initial begin : stimulus
        int         p, n, k, nmods, phase_end;
        logic [6:0] code;
        logic [6:0] held_mods [2];
        i_rst_n     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = REG_INITIAL_DELAY;
        i_cfg_data  = 8'h00;
        i_valid     = 1'b0;
        i_cmd       = CMD_KEY;
        i_key_byte  = 8'h00;
        i_map_addr  = '0;
        i_map_data  = 8'h00;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_config(8'd2, 8'd1, 1'b1, 8'h13);
        // Fill all four banks for every key the stimulus presses
        for (n = 0; n < MAP_DEPTH; n++) begin
            code = 7'(n);
            if (code == 7'h00 || (code >= 7'h10 && code <= 7'h1F) ||
                (code >= 7'h40 && code <= 7'h5F)) begin
                map_write(MAP_AW'(n), pick_map_value(code, 100));
            end
        end

        // Directed words: map extremes, letters, modifiers, stop, special keys
        map_write(9'h010, 8'h61);
        map_write(9'h090, 8'h41);
        map_write(9'h1FF, 8'hFF);
        map_write(9'h020, 8'h13);
        key_down(7'h10);
        key_down(KEY_CTRL);
        key_down(7'h10);                 // control mask
        key_up(KEY_CTRL);
        key_down(KEY_CAPS);
        key_down(7'h10);                 // caps lock picks the shifted bank
        key_up(KEY_CAPS);
        key_down(7'h20);                 // XOFF gives a stop word
        key_down(KEY_SHIFT_R);
        key_down(KEY_ALT_L);
        key_down(7'h00 ^ 7'h7F);         // top entry of the last bank
        key_down(KEY_HELP);              // two escape triples
        key_down(KEY_CTRL);
        key_down(KEY_F_LAST);            // debug code to the operator line
        key_up(KEY_CTRL);
        key_down(KEY_F_FIRST);           // shifted function index
        key_up(KEY_SHIFT_R);
        key_up(KEY_ALT_L);
        key_down(KEY_UP);
        key_down(KEY_LEFT);
        key_down(KEY_RIGHT);
        key_down(KEY_DOWN);
        tick();
        tick();                          // first repeat
        tick();                          // period repeat
        key_up(KEY_DOWN);
        tick();                          // tick while idle
        send_word(CMD_UNUSED, 8'($urandom), MAP_AW'($urandom), 8'($urandom));
        send_word(CMD_KEY, 8'hFF, MAP_AW'($urandom), 8'($urandom));
        send_word(CMD_KEY, 8'h00, MAP_AW'($urandom), 8'($urandom));
        wait_drain();

        // Long receiver hold-off while cursor words pile up and stall the input
        hold_requests++;
        for (n = 0; n < 40; n++) key_down(KEY_UP);
        key_up(KEY_UP);
        wait_drain();

        // Random phases, each with its own settings and idling mode
        for (p = 0; p < 8; p++) begin
            case (p)
                0: set_config(8'd1, 8'd1, 1'b1, 8'h13);
                1: set_config(8'd255, 8'd255, 1'b0, 8'h13);
                2: set_config(8'd3, 8'd2, 1'b1, 8'h01);
                3: set_config(8'd0, 8'd0, 1'b1, 8'hFF);
                4: set_config(8'd2, 8'd0, 1'b0, 8'h00);
                5: set_config(8'd1, 8'd255, 1'b1, 8'($urandom_range(1, 31)));
                6: set_config(8'd4, 8'd3, 1'b1, 8'h00);
                default: set_config(8'($urandom_range(1, 6)), 8'($urandom_range(1, 4)),
                                    1'($urandom), 8'($urandom));
            endcase
            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 86;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 86;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct = 27;
                end
            endcase
            phase_end = items_sent + PHASE_WORDS;
            while (items_sent < phase_end) begin
                k = $urandom_range(99);
                if (k < 60) begin
                    // modifiers, a key, some ticks, maybe a rollover, releases
                    nmods = $urandom_range(0, 2);
                    for (n = 0; n < nmods; n++) begin
                        held_mods[n] = KEY_SHIFT_L + 7'($urandom_range(0, 5));
                        key_down(held_mods[n]);
                    end
                    code = pick_key();
                    key_down(code);
                    repeat ($urandom_range(0, 10)) tick();
                    if ($urandom_range(3) == 0) begin
                        key_down(pick_key());
                        repeat ($urandom_range(0, 4)) tick();
                    end
                    if ($urandom_range(9) != 0) key_up(code);
                    for (n = 0; n < nmods; n++) key_up(held_mods[n]);
                end else if (k < 72) begin
                    repeat ($urandom_range(1, 5)) tick();
                end else if (k < 84) begin
                    code = pick_key();
                    map_write({2'($urandom), code}, pick_map_value(code, 50));
                end else if (k < 96) begin
                    send_word(CMD_KEY, {~pick_key(), 1'($urandom)}, MAP_AW'($urandom),
                              8'($urandom));
                end else begin
                    send_word(CMD_UNUSED, 8'($urandom), MAP_AW'($urandom), 8'($urandom));
                end
            end
            wait_drain();
        end

        if (fail_count == 0 && words_pending == 0) begin
            $display("keyboard_scancode_translator test passed");
        end else begin
            $display("keyboard_scancode_translator test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_NS);
        $display("keyboard_scancode_translator test failed");
        $finish;
    end

endmodule

[filelist.f]
+incdir+sv
sv/kst_pkg.sv
sv/kst_keymap.sv
sv/kst_front.sv
sv/kst_serializer.sv
sv/keyboard_scancode_translator.sv
verif/kst_translation_checker.sv
verif/keyboard_scancode_translator_tb.sv
